### hw/rtl/quaternion_to_rotation_matrix_unit_defines.svh
// Assertion macros for the quaternion to rotation matrix unit.
// Used by the top level; expects clk and rst in scope.
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2R_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("q2r check failed");
`define Q2R_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("q2r reset check failed");
`else
`define Q2R_ASSERT(name, prop)
`define Q2R_ASSERT_RST(name, prop)
`endif
`endif

### hw/rtl/q2r_pkg.sv
// Shared constants and types of the quaternion to rotation matrix unit.
// No dependencies.
package q2r_pkg;
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 2;
  localparam int PW           = 2 * SAMPLE_WIDTH;      // product width
  localparam int NW           = 2 * SAMPLE_WIDTH + 1;  // norm / remainder width
  localparam int DW           = 2 * SAMPLE_WIDTH + 3;  // signed numerator width
  localparam int QW           = FRAC_BITS + 2;         // quotient width
  localparam int NUM_ENT      = 9;
  localparam int NUM_STEPS    = FRAC_BITS + 1;
  localparam logic [QW-1:0] UNIT_Q = QW'(1) << FRAC_BITS;

  typedef logic [NW-1:0] norm_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][NW-1:0] rem;
    logic [NUM_ENT-1:0][QW-1:0] quo;
    logic [NUM_ENT-1:0]         neg;
    norm_t                      n;
    logic                       zero;
  } div_state_t;
endpackage

### hw/rtl/q2r_front.sv
// Front end: products, numerators, magnitudes and first quotient bit.
// Depends on q2r_pkg.
module q2r_front import q2r_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_w,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_x,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_y,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_z,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output div_state_t                     out_state
);
  localparam logic [SAMPLE_WIDTH-1:0] LOWEST = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  logic all_low;
  logic signed [SAMPLE_WIDTH-1:0] hw, hx, hy, hz;
  logic signed [PW-1:0] ew, ex, ey, ez;

  logic signed [PW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [DW-1:0] num [NUM_ENT];
  norm_t n2;
  logic [NW-1:0] mag3 [NUM_ENT];
  logic [NUM_ENT-1:0] neg3;
  norm_t n3;
  logic zero3;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v4;

  assign all_low = (quat_w == LOWEST) && (quat_x == LOWEST) &&
                   (quat_y == LOWEST) && (quat_z == LOWEST);
  assign hw = all_low ? (quat_w >>> 1) : quat_w;
  assign hx = all_low ? (quat_x >>> 1) : quat_x;
  assign hy = all_low ? (quat_y >>> 1) : quat_y;
  assign hz = all_low ? (quat_z >>> 1) : quat_z;
  assign ew = PW'(hw);
  assign ex = PW'(hx);
  assign ey = PW'(hy);
  assign ez = PW'(hz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      ww <= ew * ew;
      xx <= ex * ex;
      yy <= ey * ey;
      zz <= ez * ez;
      xy <= ex * ey;
      xz <= ex * ez;
      yz <= ey * ez;
      wx <= ew * ex;
      wy <= ew * ey;
      wz <= ew * ez;
    end
  end

  // numerators: diagonal n - 2s, off-diagonal 2p
  always_ff @(posedge clk) begin
    if (r2) begin
      n2 <= NW'($unsigned(ww)) + NW'($unsigned(xx)) + NW'($unsigned(yy))
            + NW'($unsigned(zz));
      num[0] <= DW'(ww) + DW'(xx) - DW'(yy) - DW'(zz);
      num[4] <= DW'(ww) - DW'(xx) + DW'(yy) - DW'(zz);
      num[8] <= DW'(ww) - DW'(xx) - DW'(yy) + DW'(zz);
      num[1] <= (DW'(xy) - DW'(wz)) <<< 1;
      num[2] <= (DW'(xz) + DW'(wy)) <<< 1;
      num[3] <= (DW'(xy) + DW'(wz)) <<< 1;
      num[5] <= (DW'(yz) - DW'(wx)) <<< 1;
      num[6] <= (DW'(xz) - DW'(wy)) <<< 1;
      num[7] <= (DW'(yz) + DW'(wx)) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      n3    <= n2;
      zero3 <= (n2 == '0);
      for (int e = 0; e < NUM_ENT; e++) begin
        neg3[e] <= num[e][DW-1];
        mag3[e] <= num[e][DW-1] ? NW'(-num[e]) : NW'(num[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      out_state.n    <= n3;
      out_state.zero <= zero3;
      out_state.neg  <= neg3;
      for (int e = 0; e < NUM_ENT; e++) begin
        if (mag3[e] >= n3) begin
          out_state.quo[e] <= QW'(1);
          out_state.rem[e] <= '0;
        end else begin
          out_state.quo[e] <= '0;
          out_state.rem[e] <= mag3[e];
        end
      end
    end
  end
endmodule

### hw/rtl/q2r_div_cell.sv
// One restoring-division cell: one quotient bit for all nine entries.
// Depends on q2r_pkg.
module q2r_div_cell import q2r_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_state_t in_state,
  output logic       out_valid,
  input  logic       out_ready,
  output div_state_t out_state
);
  logic [NW:0] r2 [NUM_ENT];
  logic [NUM_ENT-1:0] bit_q;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      r2[e]    = {1'b0, in_state.rem[e]} + {1'b0, in_state.rem[e]};
      bit_q[e] = r2[e] >= {1'b0, in_state.n};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_state.n    <= in_state.n;
      out_state.zero <= in_state.zero;
      out_state.neg  <= in_state.neg;
      for (int e = 0; e < NUM_ENT; e++) begin
        out_state.quo[e] <= {in_state.quo[e][QW-2:0], bit_q[e]};
        out_state.rem[e] <= bit_q[e] ? NW'(r2[e] - {1'b0, in_state.n}) : NW'(r2[e]);
      end
    end
  end
endmodule

### hw/rtl/q2r_back.sv
// Output stage: rounding, saturation, sign and zero-quaternion identity.
// Depends on q2r_pkg.
module q2r_back import q2r_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  div_state_t                     in_state,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] mat [NUM_ENT],
  output logic                           zero_norm
);
  logic [QW:0] rnd [NUM_ENT];
  logic [QW-1:0] mag [NUM_ENT];
  logic signed [SAMPLE_WIDTH-1:0] ent [NUM_ENT];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      rnd[e] = ({1'b0, in_state.quo[e]} + (QW+1)'(1)) >> 1;
      mag[e] = (rnd[e] > {1'b0, UNIT_Q}) ? UNIT_Q : rnd[e][QW-1:0];
      if (in_state.zero) begin
        ent[e] = (e % 4 == 0) ? SAMPLE_WIDTH'(UNIT_Q) : '0;
      end else begin
        ent[e] = in_state.neg[e] ? -SAMPLE_WIDTH'(mag[e]) : SAMPLE_WIDTH'(mag[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      mat       <= ent;
      zero_norm <= in_state.zero;
    end
  end
endmodule

### hw/rtl/quaternion_to_rotation_matrix_unit.sv
// Quaternion to rotation matrix, Q1.14 in and out.
// Pipeline: 4 front stages, 15 division cells, 1 output register.
// Throughput: one transfer per cycle while mat_stall is low; the division is a
// chain of cells, one quotient bit each, and every stage holds its item under stall.
// Reset: synchronous, clears all valid flags; no other state.
`include "quaternion_to_rotation_matrix_unit_defines.svh"
module quaternion_to_rotation_matrix_unit import q2r_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           quat_valid,
  output logic                           quat_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_w,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_x,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_y,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_z,
  output logic                           mat_valid,
  input  logic                           mat_stall,
  output logic signed [SAMPLE_WIDTH-1:0] m00,
  output logic signed [SAMPLE_WIDTH-1:0] m01,
  output logic signed [SAMPLE_WIDTH-1:0] m02,
  output logic signed [SAMPLE_WIDTH-1:0] m10,
  output logic signed [SAMPLE_WIDTH-1:0] m11,
  output logic signed [SAMPLE_WIDTH-1:0] m12,
  output logic signed [SAMPLE_WIDTH-1:0] m20,
  output logic signed [SAMPLE_WIDTH-1:0] m21,
  output logic signed [SAMPLE_WIDTH-1:0] m22,
  output logic                           zero_norm
);
  localparam logic signed [SAMPLE_WIDTH-1:0] UNIT_S = SAMPLE_WIDTH'(UNIT_Q);

  div_state_t st  [NUM_STEPS+1];
  logic       vld [NUM_STEPS+1];
  logic       rdy [NUM_STEPS+1];
  logic       in_ready;
  logic signed [SAMPLE_WIDTH-1:0] mat [NUM_ENT];

  assign quat_stall = !in_ready;

  q2r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .in_valid  (quat_valid),
    .in_ready  (in_ready),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_state (st[0])
  );

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
    q2r_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_state  (st[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_state (st[k+1])
    );
  end

  q2r_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NUM_STEPS]),
    .in_ready  (rdy[NUM_STEPS]),
    .in_state  (st[NUM_STEPS]),
    .out_valid (mat_valid),
    .out_ready (!mat_stall),
    .mat       (mat),
    .zero_norm (zero_norm)
  );

  assign m00 = mat[0];
  assign m01 = mat[1];
  assign m02 = mat[2];
  assign m10 = mat[3];
  assign m11 = mat[4];
  assign m12 = mat[5];
  assign m20 = mat[6];
  assign m21 = mat[7];
  assign m22 = mat[8];

  `Q2R_ASSERT(a_m00_range, mat_valid |-> (m00 <= UNIT_S) && (m00 >= -UNIT_S))
  `Q2R_ASSERT(a_zero_identity, (mat_valid && zero_norm) |-> (m11 == UNIT_S) && (m01 == '0))
  `Q2R_ASSERT_RST(a_reset_empty, $past(rst) |-> !mat_valid)
endmodule
